@@ rtl/smce_pkg.sv @@
// shared types, constants and coefficient tables for the softmax
// cross-entropy loss and gradient block; no dependencies
package smce_pkg;

  // sizing
  localparam int MAX_CLASSES = 32;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int CNT_W       = 6;
  localparam int CLS_W       = 5;
  localparam int LOGIT_W     = 16;
  localparam int TGT_W       = 6;
  localparam int VALUE_W     = 32;
  localparam int BATCH_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int E_W         = 17;
  localparam int S_W         = $clog2(MAX_CLASSES * 65536 + 1);
  localparam int K_W         = $clog2(S_W - 16);
  localparam int ACC_W       = 18;
  localparam int LNS_W       = 20;
  localparam int LOSS_W      = 40;
  localparam int DVD_W       = 41;
  localparam int DVS_W       = S_W;
  localparam int STEP_W      = 3;

  // fixed point constants
  localparam int ONE_Q16   = 65536;
  localparam int LOG2E_Q16 = 94548;
  localparam int LN2_Q16   = 45426;
  localparam int LN_SEED   = 7282;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE  = 1'b1;
  localparam logic [CNT_W-1:0]     NC_RESET        = 6'd32;
  localparam logic [BATCH_W-1:0]   BATCH_RESET     = 16'd1;

  // result codes
  localparam logic KIND_GRAD  = 1'b0;
  localparam logic KIND_LOSS  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_TGT = 1'b1;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic [TGT_W-1:0]          target_class;
  } logit_word_t;

  typedef struct packed {
    logic                      kind;
    logic [CLS_W-1:0]          class_index;
    logic signed [VALUE_W-1:0] value;
    logic                      status;
    logic                      last;
  } result_word_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RD_ROW_IDX, OP_RD_ROW_TGT, OP_SCAN_MAX, OP_SUM_CLR,
    OP_EXP_Y, OP_EXP_STEP, OP_EXP_WR, OP_LN_START, OP_LN_Z, OP_LN_Z2,
    OP_LN_STEP, OP_LN_FIN, OP_LOSS_ADD, OP_RD_EXP, OP_P_START, OP_Q_START,
    OP_MEAN_START, OP_OUT_ERR, OP_OUT_GRAD, OP_OUT_MEAN, OP_ROW_NEXT
  } op_t;

  typedef enum logic [1:0] {
    IDX_HOLD, IDX_INC, IDX_CLR
  } idx_op_t;

  typedef struct packed {
    op_t     op;
    idx_op_t idx_op;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic rescan;
    logic idx_last;
    logic target_bad;
    logic batch_end;
    logic step_zero;
    logic div_done;
    logic out_free;
  } status_t;

  // 2^g polynomial coefficients, Q16
  function automatic logic [E_W-1:0] pow2_coef(input logic [STEP_W-1:0] i);
    logic [E_W-1:0] c;
    case (i)
      3'd0:    c = 17'd65536;
      3'd1:    c = 17'd45426;
      3'd2:    c = 17'd15744;
      3'd3:    c = 17'd3638;
      3'd4:    c = 17'd630;
      3'd5:    c = 17'd87;
      3'd6:    c = 17'd10;
      default: c = 17'd1;
    endcase
    return c;
  endfunction

  // atanh series coefficients for ln, Q16
  function automatic logic [E_W-1:0] ln_coef(input logic [1:0] i);
    logic [E_W-1:0] c;
    case (i)
      2'd0:    c = 17'd65536;
      2'd1:    c = 17'd21845;
      2'd2:    c = 17'd13107;
      default: c = 17'd9362;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/smce_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on smce_pkg
module smce_div import smce_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int DCNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  // trial subtract
  assign rem_sh = {rem, quo[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DCNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/smce_dp.sv @@
// datapath: row and exp memories, shared multiplier, divider,
// accumulators, configuration and output register; depends on smce_pkg, smce_div
module smce_dp import smce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logit_word_t          logit_word,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_word_t         result_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration and control state
  logic [CNT_W-1:0]          nc_raw;
  logic [BATCH_W-1:0]        b_raw;
  logic [CNT_W-1:0]          class_count;
  logic signed [LOGIT_W-1:0] running_max;
  logic [TGT_W-1:0]          row_target;
  logic [BATCH_W-1:0]        row_count;
  logic [LOSS_W-1:0]         loss;
  logic [CNT_W-1:0]          idx;
  logic [STEP_W-1:0]         step;

  // payload registers
  logic signed [LOGIT_W-1:0] mx;
  logic signed [LOGIT_W-1:0] rd_row;
  logic [E_W-1:0]            erd;
  logic [32:0]               y;
  logic [ACC_W-1:0]          acc;
  logic [S_W-1:0]            s;
  logic [K_W-1:0]            k_reg;
  logic [15:0]               z;
  logic [15:0]               z2;
  logic [LNS_W-1:0]          lns;
  logic                      neg_q;

  // memories
  logic signed [LOGIT_W-1:0] row_mem [MAX_CLASSES];
  logic [E_W-1:0]            exp_mem [MAX_CLASSES];

  // combinational
  logic [CNT_W-1:0]          nc;
  logic [BATCH_W-1:0]        b;
  logic [CNT_W:0]            pos_inc;
  logic signed [LOGIT_W-1:0] cur_max;
  logic signed [LOGIT_W:0]   diff;
  logic [LOGIT_W-1:0]        u;
  logic [ACC_W-1:0]          mul_a;
  logic [E_W-1:0]            mul_b;
  logic [34:0]               prod;
  logic [E_W-1:0]            g;
  logic [8:0]                n;
  logic [E_W-1:0]            e_val;
  logic [S_W-1:0]            sl;
  logic [K_W-1:0]            k_val;
  logic [E_W-1:0]            m;
  logic [E_W-1:0]            p;
  logic [E_W-1:0]            mag;
  logic                      neg_val;
  logic                      div_start;
  logic [DVD_W-1:0]          dvd;
  logic [DVS_W-1:0]          dvs;
  logic [DVD_W-1:0]          quo;
  logic                      div_done;
  logic [VALUE_W-1:0]        q;
  logic                      out_load;
  result_word_t              res_next;

  // effective register values
  always_comb begin
    if (nc_raw == '0) nc = CNT_W'(1);
    else if (nc_raw > CNT_W'(MAX_CLASSES)) nc = CNT_W'(MAX_CLASSES);
    else nc = nc_raw;
  end
  assign b = (b_raw == '0) ? BATCH_W'(1) : b_raw;

  // row bookkeeping
  assign pos_inc = (CNT_W+1)'(class_count) + (CNT_W+1)'(1);
  always_comb begin
    if (class_count == '0) cur_max = logit_word.logit;
    else if (logit_word.logit > running_max) cur_max = logit_word.logit;
    else cur_max = running_max;
  end

  // distance from the row maximum
  assign diff = {mx[LOGIT_W-1], mx} - {rd_row[LOGIT_W-1], rd_row};
  assign u    = diff[LOGIT_W-1:0];

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_EXP_Y: begin
        mul_a = ACC_W'(u);
        mul_b = E_W'(LOG2E_Q16);
      end
      OP_EXP_STEP: begin
        mul_a = acc;
        mul_b = g;
      end
      OP_LN_Z2: begin
        mul_a = ACC_W'(z);
        mul_b = E_W'(z);
      end
      OP_LN_STEP: begin
        mul_a = acc;
        mul_b = E_W'(z2);
      end
      OP_LN_FIN: begin
        mul_a = acc;
        mul_b = E_W'(z);
      end
      default: ;
    endcase
  end
  assign prod = 35'(mul_a) * 35'(mul_b);

  // exp(-u) argument split and final shift
  assign n = y[32:24];
  assign g = E_W'(ONE_Q16) - {1'b0, y[23:8]};
  always_comb begin
    if (n >= 9'd18) e_val = '0;
    else e_val = E_W'(acc >> (n[4:0] + 5'd1));
  end

  // ln normalisation
  always_comb begin
    sl = (s < S_W'(ONE_Q16)) ? S_W'(ONE_Q16) : s;
    k_val = '0;
    for (int i = 17; i < S_W; i++) begin
      if (sl[i]) k_val = K_W'(i - 16);
    end
    m = E_W'(sl >> k_val);
  end

  // gradient magnitude from softmax
  always_comb begin
    p = quo[E_W-1:0];
    neg_val = 1'b0;
    mag = p;
    if (idx == CNT_W'(row_target)) begin
      if (p >= E_W'(ONE_Q16)) begin
        mag = p - E_W'(ONE_Q16);
      end else begin
        mag = E_W'(ONE_Q16) - p;
        neg_val = 1'b1;
      end
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b1;
    dvd = '0;
    dvs = '0;
    case (cmd.op)
      OP_LN_START: begin
        dvd = DVD_W'({m[15:0], 16'b0});
        dvs = DVS_W'(18'(m) + 18'(ONE_Q16));
      end
      OP_P_START: begin
        dvd = DVD_W'({erd, 16'b0}) + DVD_W'(s >> 1);
        dvs = s;
      end
      OP_Q_START: begin
        dvd = DVD_W'(mag) + DVD_W'(b >> 1);
        dvs = DVS_W'(b);
      end
      OP_MEAN_START: begin
        dvd = DVD_W'(loss) + DVD_W'(b >> 1);
        dvs = DVS_W'(b);
      end
      default: div_start = 1'b0;
    endcase
  end

  smce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  // result word
  assign q = quo[VALUE_W-1:0];
  always_comb begin
    res_next = '0;
    out_load = 1'b1;
    case (cmd.op)
      OP_OUT_ERR: begin
        res_next.kind   = KIND_GRAD;
        res_next.status = ST_BAD_TGT;
        res_next.last   = !status.batch_end;
      end
      OP_OUT_GRAD: begin
        res_next.kind        = KIND_GRAD;
        res_next.class_index = CLS_W'(idx);
        res_next.value       = neg_q ? -q : q;
        res_next.status      = ST_OK;
        res_next.last        = status.idx_last && !status.batch_end;
      end
      OP_OUT_MEAN: begin
        res_next.kind   = KIND_LOSS;
        res_next.value  = (|quo[DVD_W-1:31]) ? 32'h7FFF_FFFF : {1'b0, quo[30:0]};
        res_next.status = ST_OK;
        res_next.last   = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  // status to the controller
  assign status.row_end    = pos_inc >= (CNT_W+1)'(nc);
  assign status.rescan     = pos_inc != (CNT_W+1)'(nc);
  assign status.idx_last   = ((CNT_W+1)'(idx) + (CNT_W+1)'(1)) >= (CNT_W+1)'(nc);
  assign status.target_bad = row_target >= nc;
  assign status.batch_end  = ((BATCH_W+1)'(row_count) + (BATCH_W+1)'(1)) >= (BATCH_W+1)'(b);
  assign status.step_zero  = step == '0;
  assign status.div_done   = div_done;
  assign status.out_free   = !result_valid || result_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      nc_raw       <= NC_RESET;
      b_raw        <= BATCH_RESET;
      class_count  <= '0;
      running_max  <= {1'b1, {(LOGIT_W-1){1'b0}}};
      row_target   <= '0;
      row_count    <= '0;
      loss         <= '0;
      idx          <= '0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_CLASSES: nc_raw <= cfg_data[CNT_W-1:0];
          REG_BATCH_SIZE:  b_raw  <= cfg_data[BATCH_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (class_count == '0) row_target <= logit_word.target_class;
          running_max <= cur_max;
          class_count <= status.row_end ? '0 : pos_inc[CNT_W-1:0];
        end
        OP_EXP_Y:    step <= STEP_W'(6);
        OP_LN_Z2:    step <= STEP_W'(3);
        OP_EXP_STEP: step <= step - 1'b1;
        OP_LN_STEP:  step <= step - 1'b1;
        OP_LOSS_ADD: loss <= loss + LOSS_W'({u, 8'b0}) + LOSS_W'(lns);
        OP_ROW_NEXT: row_count <= row_count + 1'b1;
        OP_OUT_MEAN: begin
          loss      <= '0;
          row_count <= '0;
        end
        default: ;
      endcase
      case (cmd.idx_op)
        IDX_INC: idx <= idx + 1'b1;
        IDX_CLR: idx <= '0;
        default: ;
      endcase
      // output register
      if (out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        if (status.row_end) mx <= cur_max;
      end
      OP_SCAN_MAX: begin
        if (idx == '0 || rd_row > mx) mx <= rd_row;
      end
      OP_SUM_CLR: s <= '0;
      OP_EXP_Y: begin
        y   <= prod[32:0];
        acc <= ACC_W'(pow2_coef(STEP_W'(7)));
      end
      OP_EXP_STEP: acc <= ACC_W'(19'(pow2_coef(step)) + prod[34:16]);
      OP_EXP_WR:   s <= s + S_W'(e_val);
      OP_LN_START: k_reg <= k_val;
      OP_LN_Z:     z <= quo[15:0];
      OP_LN_Z2: begin
        z2  <= prod[31:16];
        acc <= ACC_W'(LN_SEED);
      end
      OP_LN_STEP: acc <= ACC_W'(19'(ln_coef(step[1:0])) + prod[34:16]);
      OP_LN_FIN:  lns <= LNS_W'(LN2_Q16 * k_reg) + LNS_W'({prod[32:16], 1'b0});
      OP_Q_START: neg_q <= neg_val;
      default: ;
    endcase
    if (out_load) result_word <= res_next;
  end

  // row buffer and exp store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) row_mem[class_count[IDX_W-1:0]] <= logit_word.logit;
    if (cmd.op == OP_RD_ROW_IDX) rd_row <= row_mem[idx[IDX_W-1:0]];
    if (cmd.op == OP_RD_ROW_TGT) rd_row <= row_mem[row_target[IDX_W-1:0]];
    if (cmd.op == OP_EXP_WR) exp_mem[idx[IDX_W-1:0]] <= e_val;
    if (cmd.op == OP_RD_EXP) erd <= exp_mem[idx[IDX_W-1:0]];
  end

endmodule

@@ rtl/smce_ctrl.sv @@
// controller: sequences the load, max, exp, ln, loss, gradient and
// mean passes; depends on smce_pkg
module smce_ctrl import smce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    logit_valid,
  output logic    logit_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [25:0] {
    S_IDLE        = 26'd1 << 0,
    S_SCAN_RD     = 26'd1 << 1,
    S_SCAN_MAX    = 26'd1 << 2,
    S_CHECK       = 26'd1 << 3,
    S_ERR_OUT     = 26'd1 << 4,
    S_EXP_RD      = 26'd1 << 5,
    S_EXP_Y       = 26'd1 << 6,
    S_EXP_POLY    = 26'd1 << 7,
    S_EXP_WR      = 26'd1 << 8,
    S_LN_START    = 26'd1 << 9,
    S_LN_DIV      = 26'd1 << 10,
    S_LN_Z2       = 26'd1 << 11,
    S_LN_POLY     = 26'd1 << 12,
    S_LN_FIN      = 26'd1 << 13,
    S_LOSS_RD     = 26'd1 << 14,
    S_LOSS_ADD    = 26'd1 << 15,
    S_GRAD_RD     = 26'd1 << 16,
    S_GRAD_PSTART = 26'd1 << 17,
    S_GRAD_PDIV   = 26'd1 << 18,
    S_GRAD_QSTART = 26'd1 << 19,
    S_GRAD_QDIV   = 26'd1 << 20,
    S_GRAD_OUT    = 26'd1 << 21,
    S_BATCH       = 26'd1 << 22,
    S_MEAN_START  = 26'd1 << 23,
    S_MEAN_DIV    = 26'd1 << 24,
    S_MEAN_OUT    = 26'd1 << 25
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign logit_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.idx_op = IDX_HOLD;
    case (state)
      S_IDLE: begin
        if (logit_valid) begin
          cmd.op = OP_LOAD;
          if (status.row_end) begin
            cmd.idx_op = IDX_CLR;
            state_next = status.rescan ? S_SCAN_RD : S_CHECK;
          end
        end
      end
      // row maximum over the stored entries
      S_SCAN_RD: begin
        cmd.op = OP_RD_ROW_IDX;
        state_next = S_SCAN_MAX;
      end
      S_SCAN_MAX: begin
        cmd.op = OP_SCAN_MAX;
        if (status.idx_last) begin
          cmd.idx_op = IDX_CLR;
          state_next = S_CHECK;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SCAN_RD;
        end
      end
      S_CHECK: begin
        cmd.op = OP_SUM_CLR;
        cmd.idx_op = IDX_CLR;
        state_next = status.target_bad ? S_ERR_OUT : S_EXP_RD;
      end
      S_ERR_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_OUT_ERR;
          state_next = S_BATCH;
        end
      end
      // exp pass
      S_EXP_RD: begin
        cmd.op = OP_RD_ROW_IDX;
        state_next = S_EXP_Y;
      end
      S_EXP_Y: begin
        cmd.op = OP_EXP_Y;
        state_next = S_EXP_POLY;
      end
      S_EXP_POLY: begin
        cmd.op = OP_EXP_STEP;
        if (status.step_zero) state_next = S_EXP_WR;
      end
      S_EXP_WR: begin
        cmd.op = OP_EXP_WR;
        if (status.idx_last) begin
          cmd.idx_op = IDX_CLR;
          state_next = S_LN_START;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_EXP_RD;
        end
      end
      // ln of the sum
      S_LN_START: begin
        cmd.op = OP_LN_START;
        state_next = S_LN_DIV;
      end
      S_LN_DIV: begin
        if (status.div_done) begin
          cmd.op = OP_LN_Z;
          state_next = S_LN_Z2;
        end
      end
      S_LN_Z2: begin
        cmd.op = OP_LN_Z2;
        state_next = S_LN_POLY;
      end
      S_LN_POLY: begin
        cmd.op = OP_LN_STEP;
        if (status.step_zero) state_next = S_LN_FIN;
      end
      S_LN_FIN: begin
        cmd.op = OP_LN_FIN;
        state_next = S_LOSS_RD;
      end
      // row loss
      S_LOSS_RD: begin
        cmd.op = OP_RD_ROW_TGT;
        state_next = S_LOSS_ADD;
      end
      S_LOSS_ADD: begin
        cmd.op = OP_LOSS_ADD;
        state_next = S_GRAD_RD;
      end
      // gradient pass
      S_GRAD_RD: begin
        cmd.op = OP_RD_EXP;
        state_next = S_GRAD_PSTART;
      end
      S_GRAD_PSTART: begin
        cmd.op = OP_P_START;
        state_next = S_GRAD_PDIV;
      end
      S_GRAD_PDIV: begin
        if (status.div_done) state_next = S_GRAD_QSTART;
      end
      S_GRAD_QSTART: begin
        cmd.op = OP_Q_START;
        state_next = S_GRAD_QDIV;
      end
      S_GRAD_QDIV: begin
        if (status.div_done) state_next = S_GRAD_OUT;
      end
      S_GRAD_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_OUT_GRAD;
          if (status.idx_last) begin
            cmd.idx_op = IDX_CLR;
            state_next = S_BATCH;
          end else begin
            cmd.idx_op = IDX_INC;
            state_next = S_GRAD_RD;
          end
        end
      end
      // batch end and mean loss
      S_BATCH: begin
        if (status.batch_end) begin
          state_next = S_MEAN_START;
        end else begin
          cmd.op = OP_ROW_NEXT;
          state_next = S_IDLE;
        end
      end
      S_MEAN_START: begin
        cmd.op = OP_MEAN_START;
        state_next = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        if (status.div_done) state_next = S_MEAN_OUT;
      end
      S_MEAN_OUT: begin
        if (status.out_free) begin
          cmd.op = OP_OUT_MEAN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/softmax_cross_entropy_loss_grad.sv @@
// top level of the softmax cross-entropy loss and gradient block
// depends on smce_pkg, smce_ctrl, smce_dp (which holds smce_div)
//
// usage
//   logit channel: one word per class (logit Q7.8, target_class taken on the
//   first word of a row); a row ends after num_classes words.
//   result channel: per completed row, one gradient word per class (Q15.16,
//   scaled by 1/batch_size), or a single error word when the target is out of
//   range; after batch_size rows one mean-loss word follows. last marks the
//   final word caused by a logit.
//   registers: index 0 num_classes, index 1 batch_size, written while idle.
// sequencing
//   a logit that does not end a row is taken while the sequencer stays idle.
//   after a row end no logit is taken until the exp, ln, loss and gradient
//   passes finish, with a max rescan when num_classes was lowered mid-row
//   and a mean-loss division at a batch end; each class takes two divisions
//   (softmax, then the 1/batch scaling) in the shared bit-serial divider.
// reset and stalls
//   rst clears the row, batch and loss state and sets num_classes 32 and
//   batch_size 1. results sit in an output register; while the receiver
//   stalls the sequencer holds before each further result word.
module softmax_cross_entropy_loss_grad import smce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 logit_valid,
  output logic                 logit_ready,
  input  logit_word_t          logit_word,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_word_t         result_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  smce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .logit_valid (logit_valid),
    .logit_ready (logit_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // arithmetic and storage
  smce_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .logit_word   (logit_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

@@ tb/sv/smce_checker.sv @@
`timescale 1ns / 1ps
// result checker for the softmax cross-entropy loss and gradient block
// depends on smce_pkg; mirrors the register writes and logit words it sees
module smce_checker import smce_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          logit_valid,
  input  logic          logit_ready,
  input  logit_word_t   logit_word,
  input  logic          result_valid,
  input  logic          result_ready,
  input  result_word_t  result_word,
  input  logic          cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int            fail_count,
  output int            pending
);

  result_word_t   expected_words[$];
  logic [16:0]    pow2_c [0:7];
  int             row_logit [0:MAX_CLASSES-1];
  int             row_peak;
  int             cur_target;
  int             class_pos;
  int             rows_done;
  logic [39:0]    loss_acc;
  logic [5:0]     classes_reg;
  logic [15:0]    batch_reg;

  initial begin
    pow2_c[0] = 17'd65536; pow2_c[1] = 17'd45426; pow2_c[2] = 17'd15744;
    pow2_c[3] = 17'd3638;  pow2_c[4] = 17'd630;   pow2_c[5] = 17'd87;
    pow2_c[6] = 17'd10;    pow2_c[7] = 17'd1;
  end

  // exp(-u) for a Q8 distance, Q16 result
  function automatic logic [63:0] decay_q16(input logic [31:0] u);
    logic [63:0] y, n, g, acc;
    y = 64'(u) * 64'd94548;
    n = y >> 24;
    g = 64'd65536 - ((y >> 8) & 64'hFFFF);
    acc = 64'(pow2_c[7]);
    for (int k = 6; k >= 0; k--) acc = 64'(pow2_c[k]) + ((acc * g) >> 16);
    if (n >= 40) return 64'd0;
    return acc >> (n + 1);
  endfunction

  // natural log of a Q16 sum, Q16 result
  function automatic logic [63:0] log_q16(input logic [63:0] s_in);
    logic [63:0] s, m, z, z2, acc;
    int p, k;
    s = (s_in < 64'd65536) ? 64'd65536 : s_in;
    p = 16;
    while (p < 62 && (s >> (p + 1)) != 0) p++;
    k = p - 16;
    m = s >> k;
    z = ((m - 64'd65536) << 16) / (m + 64'd65536);
    z2 = (z * z) >> 16;
    acc = 64'd7282;
    acc = 64'd9362 + ((acc * z2) >> 16);
    acc = 64'd13107 + ((acc * z2) >> 16);
    acc = 64'd21845 + ((acc * z2) >> 16);
    acc = 64'd65536 + ((acc * z2) >> 16);
    return 64'(k) * 64'd45426 + 64'd2 * ((acc * z) >> 16);
  endfunction

  // (softmax - onehot) / batch, magnitude rounded half away from zero
  function automatic logic [31:0] scaled_grad(input logic [63:0] prob, input bit hot,
                                              input logic [63:0] b);
    logic [63:0] mag, q;
    bit neg;
    neg = 0;
    mag = prob;
    if (hot) begin
      if (prob >= 64'd65536) mag = prob - 64'd65536;
      else begin
        mag = 64'd65536 - prob;
        neg = 1;
      end
    end
    q = (mag + b / 2) / b;
    return neg ? 32'(0) - q[31:0] : q[31:0];
  endfunction

  task automatic push_word(input logic kind, input int cls, input logic [31:0] val,
                           input logic st);
    result_word_t w;
    w.kind = kind;
    w.class_index = cls[4:0];
    w.value = val;
    w.status = st;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  // fold one accepted logit word into the row and batch state
  task automatic take_logit(input logit_word_t w);
    int nc, pos, mx;
    logic [63:0] b, s, lns, prob, mean;
    logic [63:0] ex [0:MAX_CLASSES-1];
    result_word_t tail;
    nc = (classes_reg == 0) ? 1 : (classes_reg > MAX_CLASSES) ? MAX_CLASSES : classes_reg;
    b = (batch_reg == 0) ? 64'd1 : 64'(batch_reg);
    pos = class_pos;
    if (pos == 0) begin
      cur_target = w.target_class;
      row_peak = -32768;
    end
    if (pos < MAX_CLASSES) row_logit[pos] = w.logit;
    if (int'(w.logit) > row_peak) row_peak = w.logit;
    if (pos + 1 < nc) begin
      class_pos = pos + 1;
      return;
    end
    mx = row_peak;
    if (pos + 1 != nc) begin
      mx = row_logit[0];
      for (int c = 1; c < nc; c++) if (row_logit[c] > mx) mx = row_logit[c];
    end
    if (cur_target >= nc) push_word(KIND_GRAD, 0, 32'd0, ST_BAD_TGT);
    else begin
      s = 0;
      for (int c = 0; c < nc; c++) begin
        ex[c] = decay_q16(32'(mx - row_logit[c]));
        s += ex[c];
      end
      if (s == 0) s = 1;
      lns = log_q16(s);
      loss_acc = 40'(64'(loss_acc) + (64'(32'(mx - row_logit[cur_target])) << 8) + lns);
      for (int c = 0; c < nc; c++) begin
        prob = (ex[c] * 64'd65536 + s / 2) / s;
        push_word(KIND_GRAD, c, scaled_grad(prob, c == cur_target, b), ST_OK);
      end
    end
    class_pos = 0;
    row_peak = -32768;
    if (64'(rows_done) + 1 >= b) begin
      mean = (64'(loss_acc) + b / 2) / b;
      if (mean > 64'h7FFFFFFF) mean = 64'h7FFFFFFF;
      push_word(KIND_LOSS, 0, mean[31:0], ST_OK);
      loss_acc = 0;
      rows_done = 0;
    end else rows_done = (rows_done + 1) & 16'hFFFF;
    tail = expected_words.pop_back();
    tail.last = 1'b1;
    expected_words.push_back(tail);
  endtask

  // compare results, track register writes, predict from logits
  always @(posedge clk) begin : watch
    result_word_t want;
    if (rst) begin
      expected_words.delete();
      fail_count = 0;
      row_peak = -32768;
      cur_target = 0;
      class_pos = 0;
      rows_done = 0;
      loss_acc = 0;
      classes_reg = NC_RESET;
      batch_reg = BATCH_RESET;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, result_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_word.kind !== want.kind || result_word.class_index !== want.class_index ||
              result_word.value !== want.value || result_word.status !== want.status ||
              result_word.last !== want.last) begin
            $display("%0t: result mismatch expected %p actual %p", $time, want, result_word);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_NUM_CLASSES) classes_reg = cfg_data[5:0];
        else batch_reg = cfg_data;
      end
      if (logit_valid && logit_ready) take_logit(logit_word);
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// top of the loss and gradient testbench: clock, reset, stimulus and verdict
// depends on smce_pkg, smce_checker and the softmax_cross_entropy_loss_grad rtl
module tb_top;
  import smce_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 logit_valid;
  logic                 logit_ready;
  logit_word_t          logit_word;
  logic                 result_valid;
  logic                 result_ready;
  result_word_t         result_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   words_sent;
  int                   cycles;
  bit                   hold_req;
  bit                   hold_taken;
  int                   hold_left;
  int                   cur_nc;

  softmax_cross_entropy_loss_grad u_dut (
    .clk(clk), .rst(rst),
    .logit_valid(logit_valid), .logit_ready(logit_ready), .logit_word(logit_word),
    .result_valid(result_valid), .result_ready(result_ready), .result_word(result_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  smce_checker u_checker (
    .clk(clk), .rst(rst),
    .logit_valid(logit_valid), .logit_ready(logit_ready), .logit_word(logit_word),
    .result_valid(result_valid), .result_ready(result_ready), .result_word(result_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1500000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    result_ready = 1'b0;
    hold_taken = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic put_logit(input logic [15:0] l, input logic [5:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      logit_valid <= 1'b0;
    end
    @(negedge clk);
    logit_valid <= 1'b1;
    logit_word <= '{logit: l, target_class: t};
    do @(posedge clk); while (!logit_ready);
    words_sent++;
  endtask

  // wait for every expected word, then let the block settle
  task automatic drain();
    @(negedge clk);
    logit_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_CLASSES) cur_nc = (val[5:0] == 0) ? 1 : (val[5:0] > 32) ? 32 : val[5:0];
  endtask

  function automatic logic [15:0] pick_logit();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 2047) - 1024);
  endfunction

  // one full row at the current class count, target mostly in range
  task automatic send_row();
    logic [5:0] t;
    t = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, cur_nc - 1))
                                      : 6'($urandom_range(0, 63));
    for (int c = 0; c < cur_nc; c++) put_logit(pick_logit(), t);
  endtask

  initial begin
    int rows;
    rst = 1'b1;
    logit_valid = 1'b0;
    logit_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NUM_CLASSES;
    cfg_data = '0;
    tx_idle_pct = 11;
    rx_idle_pct = 11;
    hold_req = 0;
    words_sent = 0;
    cur_nc = 32;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, batch of two
    write_reg(REG_NUM_CLASSES, 16'd4);
    write_reg(REG_BATCH_SIZE, 16'd2);
    put_logit(16'h7FFF, 6'd0);
    put_logit(16'h8000, 6'd0);
    put_logit(16'h0000, 6'd0);
    put_logit(16'h0001, 6'd0);
    for (int c = 0; c < 4; c++) put_logit(16'h8000, 6'd3);
    drain();
    // target out of range
    write_reg(REG_NUM_CLASSES, 16'd2);
    write_reg(REG_BATCH_SIZE, 16'd1);
    put_logit(16'd5, 6'd63);
    put_logit(16'd5, 6'd63);
    drain();
    // zero registers act as one
    write_reg(REG_NUM_CLASSES, 16'd0);
    write_reg(REG_BATCH_SIZE, 16'd0);
    put_logit(16'd100, 6'd0);
    put_logit(16'hFFFF, 6'd1);
    drain();
    // class count lowered mid-row
    write_reg(REG_NUM_CLASSES, 16'd6);
    write_reg(REG_BATCH_SIZE, 16'd3);
    put_logit(16'hFF00, 6'd2);
    put_logit(16'h0300, 6'd2);
    put_logit(16'h0500, 6'd2);
    put_logit(16'h8000, 6'd2);
    drain();
    write_reg(REG_NUM_CLASSES, 16'd2);
    put_logit(16'h0100, 6'd1);
    drain();
    // widest row with class count above the maximum, huge batch
    write_reg(REG_NUM_CLASSES, 16'd40);
    write_reg(REG_BATCH_SIZE, 16'd65535);
    send_row();
    drain();

    // random phases; a quiet stretch and one long receiver hold-off
    while (words_sent < 105 || !hold_req) begin
      if (words_sent >= 40 && words_sent < 70) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 11;
        rx_idle_pct = 11;
      end
      case ($urandom_range(0, 5))
        0: write_reg(REG_NUM_CLASSES, 16'($urandom_range(1, 3)));
        1: write_reg(REG_NUM_CLASSES, 16'($urandom_range(0, 63)));
        default: write_reg(REG_NUM_CLASSES, 16'($urandom_range(2, 8)));
      endcase
      if (cur_nc > 12 && $urandom_range(0, 2) != 0) write_reg(REG_NUM_CLASSES, 16'd5);
      write_reg(REG_BATCH_SIZE, 16'($urandom_range(0, 4)));
      if (words_sent >= 75 && !hold_req) hold_req = 1;
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) send_row();
      drain();
    end

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/smce_pkg.sv
rtl/smce_div.sv
rtl/smce_dp.sv
rtl/smce_ctrl.sv
rtl/softmax_cross_entropy_loss_grad.sv
tb/sv/smce_checker.sv
tb/sv/tb_top.sv
